/* rtl/stma_pkg.sv */
// Shared types, constants and command/status groups for the sparse triplet matrix adder.
`default_nettype none

package stma_pkg;

   localparam int CAPACITY  = 32;
   localparam int MAX_ORDER = 64;

   localparam int COORD_W = 6;
   localparam int ORDER_W = 7;
   localparam int VALUE_W = 32;
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int KEY_W   = 2 * COORD_W + IDX_W;

   localparam logic [1:0] ACT_FIRST  = 2'd0;
   localparam logic [1:0] ACT_SECOND = 2'd1;
   localparam logic [1:0] ACT_EMIT   = 2'd2;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_HDR   = 2'd1;
   localparam logic [1:0] KIND_ENTRY = 2'd2;

   typedef struct packed {
      logic [1:0]                action;
      logic [COORD_W-1:0]        row_index;
      logic [COORD_W-1:0]        col_index;
      logic signed [VALUE_W-1:0] elem_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic [ORDER_W-1:0]        out_row;
      logic [ORDER_W-1:0]        out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      table_full;
      logic                      last;
   } rsp_payload_type;

   typedef struct packed {
      logic [COORD_W-1:0]        row;
      logic [COORD_W-1:0]        col;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH,
      ST_APPEND,
      ST_ACK,
      ST_EMIT_HDR,
      ST_EMIT_START,
      ST_EMIT_SCAN,
      ST_EMIT_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic hit_write;
      logic append;
      logic out_ack;
      logic out_hdr;
      logic out_entry;
      logic emit_init;
      logic emit_next;
      logic clear_count;
   } cmd_type;

   typedef struct packed {
      logic is_first;
      logic is_second;
      logic is_emit;
      logic hit;
      logic scan_end;
      logic count_zero;
      logic emit_last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

/* rtl/stma_ctrl.sv */
// Controller state machine sequencing search, append, acknowledge and sorted emit.
`default_nettype none

module stma_ctrl import stma_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            priority if (status.is_emit) state_in = ST_EMIT_HDR;
            else if (status.is_first)    state_in = ST_APPEND;
            else if (status.is_second)   state_in = ST_SEARCH;
            else                         state_in = ST_ACK;
         end
         ST_SEARCH: begin
            priority if (status.hit)    state_in = ST_ACK;
            else if (status.scan_end)   state_in = ST_APPEND;
            else                        state_in = ST_SEARCH;
         end
         ST_APPEND: state_in = ST_ACK;
         ST_ACK: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_EMIT_HDR: begin
            if (status.out_free) begin
               state_in = status.count_zero ? ST_IDLE : ST_EMIT_START;
            end
         end
         ST_EMIT_START: state_in = ST_EMIT_SCAN;
         ST_EMIT_SCAN: begin
            if (status.scan_end) state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               state_in = status.emit_last ? ST_IDLE : ST_EMIT_START;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.scan_start = status.is_second && !status.is_emit && !status.is_first;
         end
         ST_SEARCH: begin
            cmd.scan_step = 1'b1;
            cmd.hit_write = status.hit;
         end
         ST_APPEND: cmd.append = 1'b1;
         ST_ACK:    cmd.out_ack = status.out_free;
         ST_EMIT_HDR: begin
            cmd.out_hdr   = status.out_free;
            cmd.emit_init = status.out_free;
         end
         ST_EMIT_START: cmd.scan_start = 1'b1;
         ST_EMIT_SCAN:  cmd.scan_step  = 1'b1;
         ST_EMIT_OUT: begin
            cmd.out_entry   = status.out_free;
            cmd.emit_next   = status.out_free;
            cmd.clear_count = status.out_free && status.emit_last;
         end
         default: cmd = '0;
      endcase
   end

endmodule

`default_nettype wire

/* rtl/stma_dp.sv */
// Datapath: entry memory, scan pipeline, sort selection, count and result register.
`default_nettype none

module stma_dp import stma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data,
   input  req_payload_type    req_data,
   output rsp_payload_type    rsp_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  cmd_type            cmd,
   output status_type         status
);

   entry_type entry_mem_ff [CAPACITY];

   req_payload_type           item_ff, item_in;
   logic                      full_ff, full_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [ORDER_W-1:0]        order_ff, order_in;
   logic [CNT_W-1:0]          scan_idx_ff, scan_idx_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]          rd_idx_ff;
   entry_type                 rd_entry_ff;
   logic [KEY_W-1:0]          prev_key_ff, prev_key_in;
   logic                      prev_valid_ff, prev_valid_in;
   logic [KEY_W-1:0]          best_key_ff, best_key_in;
   logic signed [VALUE_W-1:0] best_value_ff, best_value_in;
   logic                      best_valid_ff, best_valid_in;
   logic [CNT_W-1:0]          emit_cnt_ff, emit_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic [KEY_W-1:0]   rd_key;
   logic               hit;
   logic               scan_more;
   logic               room;
   logic               emit_last;
   logic               out_free;
   logic               candidate;
   logic [ORDER_W-1:0] order_sat;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic               rd_issue;

   assign rd_key    = {rd_entry_ff.row, rd_entry_ff.col, rd_idx_ff};
   assign hit       = rd_valid_ff && (rd_entry_ff.row == item_ff.row_index)
                      && (rd_entry_ff.col == item_ff.col_index);
   assign scan_more = scan_idx_ff < count_ff;
   assign room      = count_ff < CNT_W'(CAPACITY);
   assign emit_last = (emit_cnt_ff + CNT_W'(1)) == count_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign candidate = rd_valid_ff && (!prev_valid_ff || (rd_key > prev_key_ff))
                      && (!best_valid_ff || (rd_key < best_key_ff));
   assign rd_addr   = scan_idx_ff[IDX_W-1:0];
   assign rd_issue  = cmd.scan_step && scan_more;

   always_comb begin
      if (order_ff == '0) begin
         order_sat = ORDER_W'(1);
      end else if (32'(order_ff) > MAX_ORDER) begin
         order_sat = ORDER_W'(MAX_ORDER);
      end else begin
         order_sat = order_ff;
      end
   end

   always_comb begin
      wr_en = (cmd.append && room) || cmd.hit_write;
      if (cmd.hit_write) begin
         wr_addr       = rd_idx_ff;
         wr_data.row   = rd_entry_ff.row;
         wr_data.col   = rd_entry_ff.col;
         wr_data.value = rd_entry_ff.value + item_ff.elem_value;
      end else begin
         wr_addr       = count_ff[IDX_W-1:0];
         wr_data.row   = item_ff.row_index;
         wr_data.col   = item_ff.col_index;
         wr_data.value = item_ff.elem_value;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_issue) begin
         rd_entry_ff <= entry_mem_ff[rd_addr];
         rd_idx_ff   <= rd_addr;
      end
   end

   always_comb begin
      item_in       = cmd.capture ? req_data : item_ff;
      order_in      = csr_wr_en ? csr_wr_data : order_ff;

      full_in = full_ff;
      if (cmd.capture) begin
         full_in = 1'b0;
      end else if (cmd.append && !room) begin
         full_in = 1'b1;
      end

      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.append && room) begin
         count_in = count_ff + CNT_W'(1);
      end

      scan_idx_in   = scan_idx_ff;
      rd_valid_in   = rd_valid_ff;
      best_key_in   = best_key_ff;
      best_value_in = best_value_ff;
      best_valid_in = best_valid_ff;
      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         rd_valid_in   = 1'b0;
         best_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         rd_valid_in = scan_more;
         if (scan_more) scan_idx_in = scan_idx_ff + CNT_W'(1);
         if (candidate) begin
            best_key_in   = rd_key;
            best_value_in = rd_entry_ff.value;
            best_valid_in = 1'b1;
         end
      end

      prev_key_in   = prev_key_ff;
      prev_valid_in = prev_valid_ff;
      emit_cnt_in   = emit_cnt_ff;
      if (cmd.emit_init) begin
         prev_valid_in = 1'b0;
         emit_cnt_in   = '0;
      end else if (cmd.emit_next) begin
         prev_key_in   = best_key_ff;
         prev_valid_in = 1'b1;
         emit_cnt_in   = emit_cnt_ff + CNT_W'(1);
      end

      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique if (cmd.out_ack) begin
         rsp_data_in            = '0;
         rsp_data_in.kind       = KIND_ACK;
         rsp_data_in.table_full = full_ff;
         rsp_data_in.last       = 1'b1;
         rsp_valid_in           = 1'b1;
      end else if (cmd.out_hdr) begin
         rsp_data_in.kind       = KIND_HDR;
         rsp_data_in.out_row    = order_sat;
         rsp_data_in.out_col    = order_sat;
         rsp_data_in.out_value  = VALUE_W'(count_ff);
         rsp_data_in.table_full = 1'b0;
         rsp_data_in.last       = (count_ff == '0);
         rsp_valid_in           = 1'b1;
      end else if (cmd.out_entry) begin
         rsp_data_in.kind       = KIND_ENTRY;
         rsp_data_in.out_row    = ORDER_W'(best_key_ff[KEY_W-1 -: COORD_W]);
         rsp_data_in.out_col    = ORDER_W'(best_key_ff[IDX_W +: COORD_W]);
         rsp_data_in.out_value  = best_value_ff;
         rsp_data_in.table_full = 1'b0;
         rsp_data_in.last       = emit_last;
         rsp_valid_in           = 1'b1;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff       <= 1'b0;
         count_ff      <= '0;
         order_ff      <= ORDER_W'(1);
         scan_idx_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         prev_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         emit_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         full_ff       <= full_in;
         count_ff      <= count_in;
         order_ff      <= order_in;
         scan_idx_ff   <= scan_idx_in;
         rd_valid_ff   <= rd_valid_in;
         prev_valid_ff <= prev_valid_in;
         best_valid_ff <= best_valid_in;
         emit_cnt_ff   <= emit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      prev_key_ff   <= prev_key_in;
      best_key_ff   <= best_key_in;
      best_value_ff <= best_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_data  = rsp_data_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.is_first   = (item_ff.action == ACT_FIRST) && (item_ff.elem_value != '0);
   assign status.is_second  = (item_ff.action == ACT_SECOND) && (item_ff.elem_value != '0);
   assign status.is_emit    = item_ff.action == ACT_EMIT;
   assign status.hit        = hit;
   assign status.scan_end   = !scan_more && !rd_valid_ff;
   assign status.count_zero = count_ff == '0;
   assign status.emit_last  = emit_last;
   assign status.out_free   = out_free;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.append && room) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the table");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_ack || cmd.out_hdr || cmd.out_entry) |-> out_free)
      else $error("result loaded over a pending transaction");

   a_entry_selected: assert property (@(posedge clock) disable iff (reset)
      cmd.out_entry |-> best_valid_ff)
      else $error("entry emitted without a selected candidate");

   a_hit_write_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_write |-> (rd_valid_ff && !cmd.append))
      else $error("sum written without a matching read");

endmodule

`default_nettype wire

/* rtl/sparse_triplet_matrix_adder_top.sv */
// Top level of the sparse triplet matrix adder: controller plus datapath.
//
// Usage: req_valid/req_ready carry one element or emit transaction (req_data);
// rsp_valid/rsp_ready return result transactions (rsp_data). csr_wr_en writes
// the matrix order from csr_wr_data in the same cycle; write it only while idle,
// which the block leaves to the user. Element transactions (action first/second)
// return one acknowledge. An emit returns a header (order, order, count) and
// then every entry in ascending row/column order, last set on the final result;
// the table is then empty. A first-matrix element passes through decode, append
// and acknowledge; a zero element or an unused action goes from decode straight
// to acknowledge. A second-matrix element scans the entry memory one entry per
// cycle through its registered read port until it hits or reaches the end. Emit
// sends the header, then runs a selection scan over the memory for each entry.
// The block takes a new transaction once the previous one is finished; a
// result held in the output register does not block the next request.
// Reset empties the table and sets the order to 1; entry memory contents are
// not cleared. When the receiver stalls, the result stays in the output
// register and the controller waits before loading the next one.
`default_nettype none

module sparse_triplet_matrix_adder_top import stma_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_payload_type    req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_payload_type    rsp_data,
   input  logic               csr_wr_en,
   input  logic [ORDER_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   stma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stma_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

/* tb/sparse_triplet_matrix_adder_top_test.sv */
// Self-checking testbench for the sparse triplet matrix adder top level.
`default_nettype none

module sparse_triplet_matrix_adder_top_test;
   import stma_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;
   localparam rsp_payload_type ACK_OK = '{kind: KIND_ACK, out_row: 7'd0, out_col: 7'd0,
                                          out_value: 32'sd0, table_full: 1'b0, last: 1'b1};

   typedef struct {
      logic            csr;
      logic [6:0]      order;
      req_payload_type item;
      logic            typed;
      rsp_payload_type want;
   } plan_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_payload_type    req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_payload_type    rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [ORDER_W-1:0] csr_wr_data = '0;
   logic               calm = 1'b0;

   // predicted table and register
   logic [COORD_W-1:0] sum_row [CAPACITY];
   logic [COORD_W-1:0] sum_col [CAPACITY];
   logic [VALUE_W-1:0] sum_val [CAPACITY];
   int                 sum_count = 0;
   logic [ORDER_W-1:0] order_setting = 7'd1;
   rsp_payload_type    sum_results_due [$];

   int err_count = 0;
   int stall_cycles = 0;

   always #4ns clock = ~clock;

   sparse_triplet_matrix_adder_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   function automatic rsp_payload_type rsp(logic [1:0] kind, logic [6:0] r, logic [6:0] c,
                                           logic [31:0] v, logic full, logic fin);
      rsp_payload_type p;
      p.kind = kind;
      p.out_row = r;
      p.out_col = c;
      p.out_value = v;
      p.table_full = full;
      p.last = fin;
      return p;
   endfunction

   function automatic plan_row_type txn(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                                        logic [31:0] v, logic typed, rsp_payload_type want);
      plan_row_type p;
      p.csr = 1'b0;
      p.order = '0;
      p.item.action = act;
      p.item.row_index = r;
      p.item.col_index = c;
      p.item.elem_value = v;
      p.typed = typed;
      p.want = want;
      return p;
   endfunction

   function automatic plan_row_type order_row(logic [6:0] o);
      plan_row_type p;
      p = txn(ACT_FIRST, 0, 0, 0, 1'b0, ACK_OK);
      p.csr = 1'b1;
      p.order = o;
      return p;
   endfunction

   // Updates the predicted table and queues the results of one transaction.
   task automatic predict_sum(input req_payload_type item);
      int          idx [CAPACITY];
      int          i, j, n;
      logic [6:0]  ord;
      logic        full, found;
      full = 1'b0;
      found = 1'b0;
      if (item.action == ACT_EMIT) begin
         n = sum_count;
         ord = order_setting;
         if (ord < 1) ord = 1;
         if (ord > MAX_ORDER) ord = 7'(MAX_ORDER);
         // stable sort by row then column
         for (i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && {sum_row[idx[j-1]], sum_col[idx[j-1]]} >
                            {sum_row[i], sum_col[i]}) begin
               idx[j] = idx[j-1];
               j--;
            end
            idx[j] = i;
         end
         sum_results_due.push_back(rsp(KIND_HDR, ord, ord, n, 1'b0, n == 0));
         for (i = 0; i < n; i++)
            sum_results_due.push_back(rsp(KIND_ENTRY, {1'b0, sum_row[idx[i]]},
                                          {1'b0, sum_col[idx[i]]}, sum_val[idx[i]],
                                          1'b0, i == n - 1));
         sum_count = 0;
      end else begin
         if (item.action == ACT_SECOND && item.elem_value != 0) begin
            for (i = 0; i < sum_count && !found; i++) begin
               if (sum_row[i] == item.row_index && sum_col[i] == item.col_index) begin
                  sum_val[i] = sum_val[i] + item.elem_value;
                  found = 1'b1;
               end
            end
         end
         if ((item.action == ACT_FIRST || item.action == ACT_SECOND) &&
             item.elem_value != 0 && !found) begin
            if (sum_count >= CAPACITY) begin
               full = 1'b1;
            end else begin
               sum_row[sum_count] = item.row_index;
               sum_col[sum_count] = item.col_index;
               sum_val[sum_count] = item.elem_value;
               sum_count++;
            end
         end
         sum_results_due.push_back(rsp(KIND_ACK, 0, 0, 0, full, 1'b1));
      end
   endtask

   task automatic send_item(input req_payload_type item, input logic typed,
                            input rsp_payload_type want);
      int mark;
      if (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 29);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      mark = sum_results_due.size();
      predict_sum(item);
      if (typed) begin
         while (sum_results_due.size() > mark) void'(sum_results_due.pop_back());
         sum_results_due.push_back(want);
      end
   endtask

   task automatic write_order(input logic [6:0] o);
      req_valid <= 1'b0;
      while (sum_results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= o;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_setting = o;
   endtask

   task automatic note_mismatch(input string what, input rsp_payload_type want,
                                input rsp_payload_type got);
      err_count++;
      if (err_count <= 10) begin
         $display("%0t %s: exp kind=%0d row=%0d col=%0d val=%h full=%b last=%b",
                  $realtime, what, want.kind, want.out_row, want.out_col, want.out_value,
                  want.table_full, want.last);
         $display("%0t %s: got kind=%0d row=%0d col=%0d val=%h full=%b last=%b",
                  $realtime, what, got.kind, got.out_row, got.out_col, got.out_value,
                  got.table_full, got.last);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 29);
         if (rsp_valid && rsp_ready) begin
            if (sum_results_due.size() == 0) begin
               note_mismatch("unexpected result", '0, rsp_data);
            end else begin
               want = sum_results_due.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.out_row !== want.out_row ||
                   rsp_data.out_col !== want.out_col || rsp_data.out_value !== want.out_value ||
                   rsp_data.table_full !== want.table_full || rsp_data.last !== want.last)
                  note_mismatch("mismatch", want, rsp_data);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= IDLE_LIMIT) begin
         $display("FAIL sparse_triplet_matrix_adder_top");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      plan_row_type    plan [$];
      req_payload_type item;
      int              items_sent, seq, n, e, k, pick;
      logic            big;

      plan.push_back(txn(ACT_EMIT, 0, 0, 0, 1'b1, rsp(KIND_HDR, 1, 1, 0, 1'b0, 1'b1)));
      plan.push_back(txn(ACT_UNUSED, 63, 63, 32'hffff_ffff, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 5, 5, 0, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 5, 5, 0, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 63, 63, 32'h7fff_ffff, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 0, 0, 32'h8000_0000, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 0, 0, 32'h0000_0001, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 0, 0, 32'hffff_ffff, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 63, 63, 32'h0000_0001, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 10, 20, 32'd5, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 10, 20, -32'sd5, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 63, 0, 32'hffff_ffff, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 0, 63, 32'd2, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_SECOND, 42, 21, 32'h2aaa_aaaa, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 21, 42, 32'h5555_5555, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_EMIT, 63, 63, 32'hffff_ffff, 1'b0, ACK_OK));
      plan.push_back(order_row(7'(MAX_ORDER)));
      plan.push_back(txn(ACT_EMIT, 0, 0, 0, 1'b1, rsp(KIND_HDR, 64, 64, 0, 1'b0, 1'b1)));
      plan.push_back(order_row(0));
      plan.push_back(txn(ACT_EMIT, 0, 0, 0, 1'b1, rsp(KIND_HDR, 1, 1, 0, 1'b0, 1'b1)));
      plan.push_back(order_row(127));
      plan.push_back(txn(ACT_EMIT, 0, 0, 0, 1'b1, rsp(KIND_HDR, 64, 64, 0, 1'b0, 1'b1)));
      plan.push_back(order_row(37));
      plan.push_back(txn(ACT_FIRST, 1, 1, 32'd3, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_FIRST, 0, 1, 32'd4, 1'b1, ACK_OK));
      plan.push_back(txn(ACT_EMIT, 0, 0, 0, 1'b0, ACK_OK));

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].csr)
            write_order(plan[i].order);
         else
            send_item(plan[i].item, plan[i].typed, plan[i].want);
      end

      items_sent = 0;
      seq = 0;
      while (items_sent < 480) begin
         if (seq % 6 == 0) begin
            case ($urandom_range(4))
               0: write_order(1);
               1: write_order(7'(MAX_ORDER));
               2: write_order(0);
               3: write_order(127);
               default: write_order(7'($urandom_range(1, 127)));
            endcase
         end
         big = (seq == 0) || ($urandom_range(7) == 0);
         n = big ? $urandom_range(32, 40) : $urandom_range(0, 10);
         for (e = 0; e < n; e++) begin
            pick = $urandom_range(99);
            if (pick < 4) item.action = ACT_UNUSED;
            else if (pick < (big ? 90 : 50)) item.action = ACT_FIRST;
            else item.action = ACT_SECOND;
            item.row_index = ($urandom_range(1) == 1) ? 6'($urandom_range(3))
                                                      : 6'($urandom_range(63));
            item.col_index = ($urandom_range(1) == 1) ? 6'($urandom_range(3))
                                                      : 6'($urandom_range(63));
            pick = $urandom_range(99);
            if (pick < 10) begin
               item.elem_value = '0;
            end else if (pick < 20) begin
               case ($urandom_range(3))
                  0: item.elem_value = 32'h8000_0000;
                  1: item.elem_value = 32'h7fff_ffff;
                  2: item.elem_value = 32'h0000_0001;
                  default: item.elem_value = 32'hffff_ffff;
               endcase
            end else if (pick < 30 && sum_count != 0) begin
               // drive a stored sum back to zero
               k = $urandom_range(sum_count - 1);
               item.action = ACT_SECOND;
               item.row_index = sum_row[k];
               item.col_index = sum_col[k];
               item.elem_value = -sum_val[k];
            end else begin
               item.elem_value = $urandom;
            end
            if (item.action != ACT_UNUSED) items_sent++;
            calm <= (items_sent >= 150 && items_sent < 230);
            send_item(item, 1'b0, ACK_OK);
         end
         item.action = ACT_EMIT;
         item.row_index = 6'($urandom_range(63));
         item.col_index = 6'($urandom_range(63));
         item.elem_value = $urandom;
         items_sent++;
         send_item(item, 1'b0, ACK_OK);
         seq++;
      end

      req_valid <= 1'b0;
      while (sum_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0 && sum_results_due.size() == 0)
         $display("PASS sparse_triplet_matrix_adder_top");
      else
         $display("FAIL sparse_triplet_matrix_adder_top");
      $finish;
   end

endmodule

`default_nettype wire
